// ===== rtl/int128_alu_core_assert.svh =====
// assertion macros for the 128-bit alu core
// no dependencies; included by int128_alu_core.sv, the only file that carries assertions
`ifndef INT128_ALU_CORE_ASSERT_SVH
`define INT128_ALU_CORE_ASSERT_SVH
`ifndef ASSERT_OFF
`define I128_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define I128_ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define I128_ASSERT(name, clk, rst_n, prop, msg)
`define I128_ASSERT_ALWAYS(name, clk, prop, msg)
`endif
`endif

// ===== rtl/i128_pkg.sv =====
// shared constants, op codes and types of the 128-bit alu core
// no dependencies
package i128_pkg;
    localparam int WORD_BITS = 128;
    localparam int HALF_BITS = WORD_BITS / 2;
    localparam int LIMB_BITS = 32;
    localparam int NLIMB     = WORD_BITS / LIMB_BITS;
    localparam int OP_W      = 5;
    localparam int AMT_W     = 9;
    localparam int FAST_LAT  = 4;
    localparam int DIV_LAT   = WORD_BITS + 2;
    localparam int DLY_LEN   = DIV_LAT - FAST_LAT;

    localparam logic [OP_W-1:0] OP_ADD = 5'd0;
    localparam logic [OP_W-1:0] OP_SUB = 5'd1;
    localparam logic [OP_W-1:0] OP_MUL = 5'd2;
    localparam logic [OP_W-1:0] OP_DIV = 5'd3;
    localparam logic [OP_W-1:0] OP_AND = 5'd4;
    localparam logic [OP_W-1:0] OP_OR  = 5'd5;
    localparam logic [OP_W-1:0] OP_XOR = 5'd6;
    localparam logic [OP_W-1:0] OP_NOT = 5'd7;
    localparam logic [OP_W-1:0] OP_SHL = 5'd8;
    localparam logic [OP_W-1:0] OP_SAR = 5'd9;
    localparam logic [OP_W-1:0] OP_ROL = 5'd10;
    localparam logic [OP_W-1:0] OP_ROR = 5'd11;
    localparam logic [OP_W-1:0] OP_LT  = 5'd12;
    localparam logic [OP_W-1:0] OP_GT  = 5'd13;
    localparam logic [OP_W-1:0] OP_EQ  = 5'd14;
    localparam logic [OP_W-1:0] OP_NE  = 5'd15;
    localparam logic [OP_W-1:0] OP_LE  = 5'd16;
    localparam logic [OP_W-1:0] OP_GE  = 5'd17;

    typedef struct packed {
        logic [WORD_BITS-1:0] value;
        logic                 cmp;
        logic                 is_div;
    } t_fast;
endpackage

// ===== rtl/i128_fast.sv =====
// non-divide datapath: logic, add, shift, compare and the 4-stage multiplier
// depends on i128_pkg
module i128_fast (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [i128_pkg::OP_W-1:0]      i_op,
    input  logic [i128_pkg::WORD_BITS-1:0] i_a,
    input  logic [i128_pkg::WORD_BITS-1:0] i_b,
    input  logic [i128_pkg::AMT_W-1:0]     i_amt,
    output i128_pkg::t_fast                o_res
);
    import i128_pkg::*;

    logic [WORD_BITS-1:0] n_simple;
    logic                 n_cmp;
    logic                 slt_ab, slt_ba, eq_ab;
    logic                 amt_neg;
    logic [AMT_W-1:0]     amt_mag;
    logic [WORD_BITS-1:0] shl_v, sar_v;

    logic [WORD_BITS-1:0] r1_simple;
    logic                 r1_cmp, r1_mul, r1_div;
    logic [2*LIMB_BITS-1:0] r1_pp [NLIMB][NLIMB];

    logic [WORD_BITS-1:0] n_col [NLIMB];
    logic [WORD_BITS-1:0] r2_col [NLIMB];
    logic [WORD_BITS-1:0] r2_simple;
    logic                 r2_cmp, r2_mul, r2_div;

    logic [WORD_BITS-1:0] r3_lo, r3_hi, r3_simple;
    logic                 r3_cmp, r3_mul, r3_div;

    t_fast r4_res;

    assign slt_ab  = $signed(i_a) < $signed(i_b);
    assign slt_ba  = $signed(i_b) < $signed(i_a);
    assign eq_ab   = (i_a == i_b);
    assign amt_neg = i_amt[AMT_W-1];
    assign amt_mag = amt_neg ? (~i_amt + 1'b1) : i_amt;
    assign shl_v   = i_a << amt_mag;
    assign sar_v   = WORD_BITS'($signed(i_a) >>> amt_mag);

    always_comb begin
        n_simple = '0;
        n_cmp    = 1'b0;
        case (i_op)
            OP_ADD: n_simple = i_a + i_b;
            OP_SUB: n_simple = i_a - i_b;
            OP_AND: n_simple = i_a & i_b;
            OP_OR:  n_simple = i_a | i_b;
            OP_XOR: n_simple = i_a ^ i_b;
            OP_NOT: n_simple = ~i_a;
            OP_SHL: n_simple = amt_neg ? sar_v : shl_v;
            OP_SAR: n_simple = amt_neg ? shl_v : sar_v;
            OP_ROL: n_simple = {i_a[WORD_BITS-2:0], i_a[WORD_BITS-1]};
            OP_ROR: n_simple = {i_a[0], i_a[WORD_BITS-1:1]};
            OP_LT:  n_cmp = slt_ab;
            OP_GT:  n_cmp = slt_ba;
            OP_EQ:  n_cmp = eq_ab;
            OP_NE:  n_cmp = !eq_ab;
            OP_LE:  n_cmp = !slt_ba;
            OP_GE:  n_cmp = !slt_ab;
            default: n_simple = '0;
        endcase
    end

    // stage 1: limb partial products, only those that reach the low word
    for (genvar gi = 0; gi < NLIMB; gi++) begin : g_pi
        for (genvar gj = 0; gj < NLIMB - gi; gj++) begin : g_pj
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r1_pp[gi][gj] <= i_a[gi*LIMB_BITS +: LIMB_BITS]
                                   * i_b[gj*LIMB_BITS +: LIMB_BITS];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_simple <= n_simple;
            r1_cmp    <= n_cmp;
            r1_mul    <= (i_op == OP_MUL);
            r1_div    <= (i_op == OP_DIV);
        end
    end

    // stage 2: sum each column of equal weight
    always_comb begin
        for (int k = 0; k < NLIMB; k++) begin
            n_col[k] = '0;
            for (int i = 0; i <= k; i++) begin
                n_col[k] = n_col[k]
                         + (WORD_BITS'(r1_pp[i][k-i]) << (LIMB_BITS * k));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_col    <= n_col;
            r2_simple <= r1_simple;
            r2_cmp    <= r1_cmp;
            r2_mul    <= r1_mul;
            r2_div    <= r1_div;
        end
    end

    // stage 3 and 4: pairwise then final add
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r3_lo     <= r2_col[0] + r2_col[1];
            r3_hi     <= r2_col[2] + r2_col[3];
            r3_simple <= r2_simple;
            r3_cmp    <= r2_cmp;
            r3_mul    <= r2_mul;
            r3_div    <= r2_div;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r4_res.value  <= r3_mul ? (r3_lo + r3_hi) : r3_simple;
            r4_res.cmp    <= r3_cmp;
            r4_res.is_div <= r3_div;
        end
    end

    assign o_res = r4_res;
endmodule

// ===== rtl/i128_div.sv =====
// pipelined signed restoring divider, one quotient bit per stage
// depends on i128_pkg
module i128_div (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic [i128_pkg::WORD_BITS-1:0] i_a,
    input  logic [i128_pkg::WORD_BITS-1:0] i_b,
    output logic [i128_pkg::WORD_BITS-1:0] o_quot,
    output logic                           o_dz
);
    import i128_pkg::*;

    logic [WORD_BITS-1:0] r_n   [0:WORD_BITS];
    logic                 r_neg [0:WORD_BITS];
    logic                 r_dz  [0:WORD_BITS];
    logic [WORD_BITS-1:0] r_rem [0:WORD_BITS-1];
    logic [WORD_BITS-1:0] r_d   [0:WORD_BITS-1];
    logic [WORD_BITS-1:0] r_quot;
    logic                 r_qdz;

    // prep stage: magnitudes, sign and zero divisor
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_n[0]   <= i_a[WORD_BITS-1] ? (~i_a + 1'b1) : i_a;
            r_d[0]   <= i_b[WORD_BITS-1] ? (~i_b + 1'b1) : i_b;
            r_rem[0] <= '0;
            r_neg[0] <= i_a[WORD_BITS-1] ^ i_b[WORD_BITS-1];
            r_dz[0]  <= (i_b == '0);
        end
    end

    for (genvar k = 1; k <= WORD_BITS; k++) begin : g_step
        logic [WORD_BITS-1:0] rs;
        logic [WORD_BITS:0]   diff;
        logic                 ge;

        assign rs   = {r_rem[k-1][WORD_BITS-2:0], r_n[k-1][WORD_BITS-1]};
        assign diff = {1'b0, rs} - {1'b0, r_d[k-1]};
        assign ge   = !diff[WORD_BITS];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_n[k]   <= {r_n[k-1][WORD_BITS-2:0], ge};
                r_neg[k] <= r_neg[k-1];
                r_dz[k]  <= r_dz[k-1];
            end
        end

        if (k < WORD_BITS) begin : g_carry
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k] <= ge ? diff[WORD_BITS-1:0] : rs;
                    r_d[k]   <= r_d[k-1];
                end
            end
        end
    end

    // fixup stage: restore sign, force zero on divide by zero
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_dz[WORD_BITS]) begin
                r_quot <= '0;
            end else if (r_neg[WORD_BITS]) begin
                r_quot <= ~r_n[WORD_BITS] + 1'b1;
            end else begin
                r_quot <= r_n[WORD_BITS];
            end
            r_qdz <= r_dz[WORD_BITS];
        end
    end

    assign o_quot = r_quot;
    assign o_dz   = r_qdz;
endmodule

// ===== rtl/int128_alu_core.sv =====
// 128-bit signed alu, pipelined from input transfer to o_valid
// throughput one transfer per cycle while the output is not stalled; the divider sets the depth
// every op travels the same depth so results leave in input order
// a stall at the output freezes the whole pipeline, nothing is lost
// synchronous active-low reset clears all valid bits, payload is not reset
// depends on i128_pkg, i128_fast, i128_div and int128_alu_core_assert.svh
`include "int128_alu_core_assert.svh"
module int128_alu_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [i128_pkg::OP_W-1:0]      i_op,
    input  logic [i128_pkg::HALF_BITS-1:0] i_first_high,
    input  logic [i128_pkg::HALF_BITS-1:0] i_first_low,
    input  logic [i128_pkg::HALF_BITS-1:0] i_second_high,
    input  logic [i128_pkg::HALF_BITS-1:0] i_second_low,
    input  logic [i128_pkg::AMT_W-1:0]     i_shift_amount,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [i128_pkg::HALF_BITS-1:0] o_value_high,
    output logic [i128_pkg::HALF_BITS-1:0] o_value_low,
    output logic                           o_compare_true,
    output logic                           o_divide_by_zero
);
    import i128_pkg::*;

    // global advance: the pipe moves whenever the output register can take
    logic en;

    // input capture stage
    logic                 r_v0;
    logic [OP_W-1:0]      r_op;
    logic [WORD_BITS-1:0] r_a, r_b;
    logic [AMT_W-1:0]     r_amt;

    // valid bits that follow the data through the divider depth
    logic r_vld [0:DIV_LAT-1];

    // fast path result, delayed to match the divider
    t_fast fast_res;
    t_fast r_dly [0:DLY_LEN-1];

    logic [WORD_BITS-1:0] div_quot;
    logic                 div_dz;

    // output register
    logic                 r_out_valid;
    logic [WORD_BITS-1:0] r_out_value;
    logic                 r_out_cmp, r_out_dz;

    assign en      = !r_out_valid || i_ready;
    assign o_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_op  <= i_op;
            r_a   <= {i_first_high, i_first_low};
            r_b   <= {i_second_high, i_second_low};
            r_amt <= i_shift_amount;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= r_v0;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    i128_fast u_fast (
        .i_clk (i_clk),
        .i_en  (en),
        .i_op  (r_op),
        .i_a   (r_a),
        .i_b   (r_b),
        .i_amt (r_amt),
        .o_res (fast_res)
    );

    i128_div u_div (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_a    (r_a),
        .i_b    (r_b),
        .o_quot (div_quot),
        .o_dz   (div_dz)
    );

    // delay line so the fast ops line up with the divider output
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= fast_res;
            for (int k = 1; k < DLY_LEN; k++) begin
                r_dly[k] <= r_dly[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= r_vld[DIV_LAT-1];
        end
    end

    // pick divider or fast result for the op in the last stage
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_dly[DLY_LEN-1].is_div) begin
                r_out_value <= div_quot;
                r_out_dz    <= div_dz;
            end else begin
                r_out_value <= r_dly[DLY_LEN-1].value;
                r_out_dz    <= 1'b0;
            end
            r_out_cmp <= r_dly[DLY_LEN-1].cmp;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_value_high     = r_out_value[WORD_BITS-1:HALF_BITS];
    assign o_value_low      = r_out_value[HALF_BITS-1:0];
    assign o_compare_true   = r_out_cmp;
    assign o_divide_by_zero = r_out_dz;

    // a transfer always lands in the capture stage
    `I128_ASSERT(a_capture, i_clk, i_rst_n, (i_valid && o_ready) |=> r_v0, "transfer not captured")
    // a frozen pipe keeps its tail valid bit
    `I128_ASSERT(a_hold, i_clk, i_rst_n, !en |=> $stable(r_vld[DIV_LAT-1]), "tail moved while stalled")
    // divide by zero gives a zero value and no compare flag
    `I128_ASSERT(a_dz_zero, i_clk, i_rst_n, (o_valid && o_divide_by_zero) |-> (r_out_value == '0 && !o_compare_true), "bad divide by zero result")
    // compare results carry a zero value
    `I128_ASSERT(a_cmp_zero, i_clk, i_rst_n, (o_valid && o_compare_true) |-> (r_out_value == '0), "compare with nonzero value")
    // reset empties the output
    `I128_ASSERT_ALWAYS(a_rst, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
endmodule

// ===== tb/int128_alu_core_test.sv =====
// self-checking testbench of the 128-bit signed alu core
// depends on i128_pkg and the int128_alu_core rtl
`timescale 1ns / 1ps
module int128_alu_core_test;
    import i128_pkg::*;

    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        logic        cmp;
        logic        dz;
    } alu_result_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [4:0]  i_op = '0;
    logic [63:0] i_first_high = '0, i_first_low = '0;
    logic [63:0] i_second_high = '0, i_second_low = '0;
    logic [8:0]  i_shift_amount = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [63:0] o_value_high, o_value_low;
    logic        o_compare_true, o_divide_by_zero;

    // idle percentages for sender and receiver, changed per phase
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned hold_off_cycles = 0;
    int unsigned mismatch_count = 0;
    alu_result_t pending_results[$];

    int128_alu_core dut (.*);

    always #2 i_clk = ~i_clk;

    // signed divide with magnitudes in 129 bits so that 2^127 is exact
    function automatic logic [127:0] signed_quotient(logic [127:0] a, logic [127:0] b);
        logic [128:0] ma, mb, q;
        ma = a[127] ? {1'b0, -a} : {1'b0, a};
        mb = b[127] ? {1'b0, -b} : {1'b0, b};
        if (a == {1'b1, 127'b0}) ma = {2'b01, 127'b0};
        if (b == {1'b1, 127'b0}) mb = {2'b01, 127'b0};
        q = ma / mb;
        return (a[127] != b[127]) ? -q[127:0] : q[127:0];
    endfunction

    function automatic logic [127:0] shift_word(logic [127:0] x, bit left, int unsigned n);
        if (n >= WORD_BITS) return left ? '0 : {128{x[127]}};
        return left ? (x << n) : 128'($signed(x) >>> n);
    endfunction

    function automatic alu_result_t alu_compute(logic [4:0] op, logic [127:0] a,
                                                logic [127:0] b, logic [8:0] amt);
        alu_result_t r;
        logic [127:0] v;
        bit neg;
        int unsigned mag;
        v = '0;
        r.cmp = 1'b0;
        r.dz = 1'b0;
        neg = amt[8];
        mag = neg ? 512 - amt : amt;
        case (op)
            OP_ADD: v = a + b;
            OP_SUB: v = a - b;
            OP_MUL: v = a * b;
            OP_DIV: begin
                if (b == '0) r.dz = 1'b1;
                else v = signed_quotient(a, b);
            end
            OP_AND: v = a & b;
            OP_OR:  v = a | b;
            OP_XOR: v = a ^ b;
            OP_NOT: v = ~a;
            OP_SHL: v = shift_word(a, !neg, mag);
            OP_SAR: v = shift_word(a, neg, mag);
            OP_ROL: v = {a[126:0], a[127]};
            OP_ROR: v = {a[0], a[127:1]};
            OP_LT:  r.cmp = $signed(a) < $signed(b);
            OP_GT:  r.cmp = $signed(a) > $signed(b);
            OP_EQ:  r.cmp = a == b;
            OP_NE:  r.cmp = a != b;
            OP_LE:  r.cmp = $signed(a) <= $signed(b);
            OP_GE:  r.cmp = $signed(a) >= $signed(b);
            default: ;
        endcase
        r.hi = v[127:64];
        r.lo = v[63:0];
        return r;
    endfunction

    // drive one item at the falling edge and hold it until the transfer
    task automatic send_item(logic [4:0] op, logic [127:0] a, logic [127:0] b,
                             logic [8:0] amt);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_op <= op;
        {i_first_high, i_first_low} <= a;
        {i_second_high, i_second_low} <= b;
        i_shift_amount <= amt;
        pending_results.push_back(alu_compute(op, a, b, amt));
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // receiver ready, random stalls and a counted long hold-off
    always @(negedge i_clk) begin
        if (hold_off_cycles != 0) begin
            i_ready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            i_ready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // result checker
    always @(posedge i_clk) begin
        alu_result_t e;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected result transfer");
            end else begin
                e = pending_results.pop_front();
                if (e.hi !== o_value_high || e.lo !== o_value_low ||
                    e.cmp !== o_compare_true || e.dz !== o_divide_by_zero) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("exp %h_%h c%b z%b got %h_%h c%b z%b",
                                 e.hi, e.lo, e.cmp, e.dz, o_value_high,
                                 o_value_low, o_compare_true, o_divide_by_zero);
                end
            end
        end
    end

    function automatic logic [127:0] rand_word();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return {1'b1, 127'b0};
            3: return 128'($urandom_range(20)) - 128'd10;
            default: return {$urandom, $urandom, $urandom, $urandom};
        endcase
    endfunction

    // sender goes idle until every expected result has come
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending_results.size() != 0);
    endtask

    localparam logic [127:0] MIN_W = {1'b1, 127'b0};
    localparam logic [127:0] MAX_W = {1'b0, {127{1'b1}}};

    task automatic test_directed();
        send_item(OP_ADD, MAX_W, 128'd1, 9'd0);
        send_item(OP_SUB, MIN_W, 128'd1, 9'd0);
        send_item(OP_MUL, '1, '1, 9'd0);
        send_item(OP_DIV, 128'd7, '0, 9'd0);
        send_item(OP_DIV, MIN_W, '1, 9'd0);
        send_item(OP_DIV, MIN_W, MIN_W, 9'd0);
        send_item(OP_DIV, -128'd7, 128'd2, 9'd0);
        send_item(OP_AND, '1, MIN_W, 9'h1ff);
        send_item(OP_OR, MIN_W, 128'd1, 9'd0);
        send_item(OP_XOR, '1, MAX_W, 9'd0);
        send_item(OP_NOT, '0, '1, 9'd0);
        send_item(OP_SHL, '1, '0, 9'd255);
        send_item(OP_SHL, MIN_W, '0, -9'sd3);
        send_item(OP_SAR, MIN_W, '0, 9'd128);
        send_item(OP_SAR, 128'd5, '0, -9'sd255);
        send_item(OP_SAR, MIN_W, '0, 9'd64);
        send_item(OP_ROL, MIN_W, '0, 9'd5);
        send_item(OP_ROR, 128'd1, '0, 9'd0);
        send_item(OP_LT, MIN_W, MAX_W, 9'd0);
        send_item(OP_GT, MIN_W, MAX_W, 9'd0);
        send_item(OP_EQ, '1, '1, 9'd0);
        send_item(OP_NE, '1, '1, 9'd0);
        send_item(OP_LE, MAX_W, MAX_W, 9'd0);
        send_item(OP_GE, '0, '1, 9'd0);
        send_item(5'd31, '1, '1, 9'h1ff);
        drain_results();
    endtask

    task automatic test_random(int unsigned n, int unsigned s_pct, int unsigned r_pct);
        logic [4:0] op;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        repeat (n) begin
            // mostly defined op codes, a few unused ones
            op = ($urandom_range(19) == 0) ? 5'($urandom_range(31, 18))
                                           : 5'($urandom_range(17));
            send_item(op, rand_word(), rand_word(), 9'($urandom));
        end
        drain_results();
    endtask

    // receiver blocked far past pipeline depth while the sender keeps going
    task automatic test_back_pressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        @(negedge i_clk);
        hold_off_cycles = 3 * DIV_LAT;
        repeat (DIV_LAT + 40) send_item(5'($urandom_range(17)), rand_word(),
                                        rand_word(), 9'($urandom));
        drain_results();
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_random(150, 0, 0);
        test_random(110, 49, 0);
        test_random(110, 0, 49);
        test_random(110, 33, 33);
        test_back_pressure();
        repeat (DIV_LAT + 10) @(negedge i_clk);
        if (mismatch_count == 0 && pending_results.size() == 0)
            $display("int128_alu_core: match");
        else
            $display("int128_alu_core: mismatch");
        $finish;
    end

    initial begin
        #2000000;
        $display("int128_alu_core: mismatch");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/i128_pkg.sv
rtl/i128_fast.sv
rtl/i128_div.sv
rtl/int128_alu_core.sv
tb/int128_alu_core_test.sv
